>>> rtl/windowed_throughput_estimator_core_macros.svh
// ----------------------------------------------------------------------------
// windowed throughput estimator assertion macros
// concurrent assertion wrappers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef WINDOWED_THROUGHPUT_ESTIMATOR_CORE_MACROS_SVH
`define WINDOWED_THROUGHPUT_ESTIMATOR_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define WTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define WTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WTE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define WTE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/wte_pkg.sv
// ----------------------------------------------------------------------------
// wte_pkg
// shared widths, constants and divider handshake types
// ----------------------------------------------------------------------------
package wte_pkg;

	localparam int TIME_W  = 24;
	localparam int BYTES_W = 32;
	localparam int COUNT_W = 31;
	localparam int STEP_W  = 6;
	localparam int PROD_W  = 56;

	localparam logic [TIME_W-1:0]  WINDOW_RESET    = 24'd8000;
	localparam logic [9:0]         MS_PER_S        = 10'd1000;
	localparam logic [COUNT_W-1:0] RATE_MAX        = 31'h7fff_ffff;
	localparam logic [BYTES_W-1:0] BYTES_MAX       = 32'hffff_ffff;
	localparam logic [STEP_W-1:0]  DIV_STEPS_PART  = 6'd32;
	localparam logic [STEP_W-1:0]  DIV_STEPS_RATE  = 6'd31;

	// item commands
	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	// divider request from the sequencer
	typedef struct packed {
		logic               start;
		logic [TIME_W-1:0]  rem_init;
		logic [BYTES_W-1:0] dvd;
		logic [TIME_W-1:0]  divisor;
		logic [STEP_W-1:0]  steps;
	} wte_div_req_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic               busy;
		logic               done;
		logic [BYTES_W-1:0] quot;
	} wte_div_rsp_t;

endpackage

>>> rtl/wte_serial_div.sv
// ----------------------------------------------------------------------------
// wte_serial_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`include "windowed_throughput_estimator_core_macros.svh"

module wte_serial_div
	import wte_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wte_div_req_t req,
	output wte_div_rsp_t rsp
);

	logic               busy_q;
	logic               done_q;
	logic [STEP_W-1:0]  cnt_q;
	logic [TIME_W-1:0]  rem_q;
	logic [TIME_W-1:0]  div_q;
	logic [BYTES_W-1:0] dvd_q;
	logic [BYTES_W-1:0] quot_q;

	logic [TIME_W:0]    rem_sh;
	logic [TIME_W:0]    rem_diff;
	logic               rem_ge;

	// shift in the next dividend bit and trial subtract
	assign rem_sh   = {rem_q, dvd_q[BYTES_W-1]};
	assign rem_diff = rem_sh - {1'b0, div_q};
	assign rem_ge   = rem_sh >= {1'b0, div_q};

	// iteration control and datapath shift registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
				rem_q  <= req.rem_init;
				div_q  <= req.divisor;
				dvd_q  <= req.dvd;
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= rem_ge ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
				quot_q <= {quot_q[BYTES_W-2:0], rem_ge};
				dvd_q  <= {dvd_q[BYTES_W-2:0], 1'b0};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

	// checks
	`WTE_ASSERT_IMP(a_div_start_idle, clk, arst_n, req.start, !busy_q, "divider restarted while busy")
	`WTE_ASSERT_IMP(a_div_rem_bound, clk, arst_n, busy_q, rem_q < div_q, "partial remainder not below divisor")
	`WTE_ASSERT_NXT(a_div_done_idle, clk, arst_n, done_q, !done_q && !busy_q, "done not a single pulse")

endmodule

>>> rtl/windowed_throughput_estimator_core.sv
// ----------------------------------------------------------------------------
// windowed_throughput_estimator_core
// sliding window throughput estimate over a bucketed (time, bytes) history
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_stall) carries cmd, byte_count, elapsed_ms and
//   idle_ms; cmd set clears the history and returns a rate of 0.
//   output channel (out_valid/out_stall) returns one rate_bytes_per_s per item.
//   cfg channel (cfg_valid/cfg_ready) writes window_ms; ready only while idle.
// sequence, one item at a time:
//   clear: straight to ST_OUT, then to the output register.
//   update: the rotating walk over all NUM_SAMPLES buckets, a bit-serial divide
//   for the partial bucket (32 steps) when a bucket straddles the window edge,
//   and a bit-serial divide for the rate (31 steps) unless the rate is 0 or
//   saturates.
// reset: history zeroed, window_ms = 8000, no result pending.
// stall: a finished result waits in ST_OUT until the output register is free;
//   the next item can be taken while the last result sits in that register.
// ----------------------------------------------------------------------------
`include "windowed_throughput_estimator_core_macros.svh"

module windowed_throughput_estimator_core
	import wte_pkg::*;
#(
	parameter int NUM_SAMPLES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [COUNT_W-1:0] byte_count,
	input  logic [TIME_W-1:0]  elapsed_ms,
	input  logic [TIME_W-1:0]  idle_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [COUNT_W-1:0] rate_bytes_per_s,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [TIME_W-1:0]  cfg_data
);

	localparam int CW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_WALK,
		ST_PMUL,
		ST_PSTART,
		ST_PDIV,
		ST_RMUL,
		ST_RSTART,
		ST_RDIV,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [TIME_W-1:0]  win_q;
	logic [TIME_W-1:0]  bucket_time_q  [NUM_SAMPLES];
	logic [BYTES_W-1:0] bucket_bytes_q [NUM_SAMPLES];
	logic [COUNT_W-1:0] nbytes_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [TIME_W-1:0]  idle_q;
	logic [CW-1:0]      cnt_q;
	logic [TIME_W-1:0]  t_q;
	logic [BYTES_W-1:0] bytes_q;
	logic               cross_q;
	logic [TIME_W-1:0]  part_a_q;
	logic [BYTES_W-1:0] part_ds_q;
	logic [TIME_W-1:0]  part_dt_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COUNT_W-1:0] res_q;
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_rate_q;

	logic               in_acc;
	logic               out_free;
	logic [TIME_W:0]    merge_sum;
	logic [TIME_W+1:0]  merge_sum1;
	logic [31:0]        merge_lhs;
	logic               merge_ok;
	logic [BYTES_W:0]   merge_bytes;
	logic [TIME_W:0]    walk_sum;
	logic               walk_act;
	logic               walk_cross;
	logic [BYTES_W:0]   walk_bytes;
	logic [BYTES_W:0]   part_bytes;
	logic               rate_sat;
	wte_div_req_t       div_req;
	wte_div_rsp_t       div_rsp;

	assign in_acc    = in_valid && !in_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;

	// merge test: sum < window / N  <=>  (sum + 1) * N <= window
	assign merge_sum   = {1'b0, bucket_time_q[0]} + {1'b0, elapsed_q};
	assign merge_sum1  = {1'b0, merge_sum} + 1'b1;
	assign merge_lhs   = 32'(merge_sum1) * 32'(NUM_SAMPLES);
	assign merge_ok    = merge_lhs <= {8'b0, win_q};
	assign merge_bytes = {1'b0, bucket_bytes_q[0]} + {2'b0, nbytes_q};

	// walk step on the bucket at the head of the rotating history
	assign walk_sum   = {1'b0, t_q} + {1'b0, bucket_time_q[0]};
	assign walk_act   = t_q < win_q;
	assign walk_cross = walk_act && (walk_sum > {1'b0, win_q});
	assign walk_bytes = {1'b0, bytes_q} + {1'b0, bucket_bytes_q[0]};
	assign part_bytes = {1'b0, bytes_q} + {1'b0, div_rsp.quot};

	// quotient of 1000 * bytes / t reaches 2^31 when the top bits cover t
	assign rate_sat = {13'b0, prod_q[41:31]} >= t_q;

	// divider request
	always_comb begin
		div_req.start    = 1'b0;
		div_req.rem_init = prod_q[PROD_W-1:BYTES_W];
		div_req.dvd      = prod_q[BYTES_W-1:0];
		div_req.divisor  = part_dt_q;
		div_req.steps    = DIV_STEPS_PART;
		case (state_q)
			ST_PSTART: begin
				div_req.start = 1'b1;
			end
			ST_RSTART: begin
				div_req.start    = !rate_sat;
				div_req.rem_init = {13'b0, prod_q[41:31]};
				div_req.dvd      = {prod_q[30:0], 1'b0};
				div_req.divisor  = t_q;
				div_req.steps    = DIV_STEPS_RATE;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	wte_serial_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer, bucket history and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WINDOW_RESET;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
			cross_q     <= 1'b0;
			for (int i = 0; i < NUM_SAMPLES; i++) begin
				bucket_time_q[i]  <= '0;
				bucket_bytes_q[i] <= '0;
			end
		end else begin
			// output register: load a finished result, drop it once taken
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				out_rate_q  <= res_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				win_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						nbytes_q  <= byte_count;
						elapsed_q <= elapsed_ms;
						idle_q    <= idle_ms;
						if (cmd == CMD_CLEAR) begin
							for (int i = 0; i < NUM_SAMPLES; i++) begin
								bucket_time_q[i]  <= '0;
								bucket_bytes_q[i] <= '0;
							end
							res_q   <= '0;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_UPDATE;
						end
					end
				end
				ST_UPDATE: begin
					if (merge_ok) begin
						bucket_time_q[0]  <= merge_sum[TIME_W-1:0];
						bucket_bytes_q[0] <= merge_bytes[BYTES_W] ? BYTES_MAX
							: merge_bytes[BYTES_W-1:0];
					end else begin
						for (int i = NUM_SAMPLES - 1; i > 0; i--) begin
							bucket_time_q[i]  <= bucket_time_q[i-1];
							bucket_bytes_q[i] <= bucket_bytes_q[i-1];
						end
						bucket_time_q[0]  <= elapsed_q;
						bucket_bytes_q[0] <= {1'b0, nbytes_q};
					end
					t_q     <= idle_q;
					bytes_q <= '0;
					cross_q <= 1'b0;
					cnt_q   <= '0;
					state_q <= ST_WALK;
				end
				ST_WALK: begin
					if (walk_cross) begin
						part_a_q  <= win_q - t_q;
						part_ds_q <= bucket_bytes_q[0];
						part_dt_q <= bucket_time_q[0];
						cross_q   <= 1'b1;
						t_q       <= win_q;
					end else if (walk_act) begin
						t_q     <= walk_sum[TIME_W-1:0];
						bytes_q <= walk_bytes[BYTES_W] ? BYTES_MAX : walk_bytes[BYTES_W-1:0];
					end
					// rotate so every bucket passes the head once
					for (int i = 0; i < NUM_SAMPLES - 1; i++) begin
						bucket_time_q[i]  <= bucket_time_q[i+1];
						bucket_bytes_q[i] <= bucket_bytes_q[i+1];
					end
					bucket_time_q[NUM_SAMPLES-1]  <= bucket_time_q[0];
					bucket_bytes_q[NUM_SAMPLES-1] <= bucket_bytes_q[0];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(NUM_SAMPLES - 1)) begin
						state_q <= (cross_q || walk_cross) ? ST_PMUL : ST_RMUL;
					end
				end
				ST_PMUL: begin
					prod_q  <= {32'b0, part_a_q} * {24'b0, part_ds_q};
					state_q <= ST_PSTART;
				end
				ST_PSTART: begin
					state_q <= ST_PDIV;
				end
				ST_PDIV: begin
					if (div_rsp.done) begin
						bytes_q <= part_bytes[BYTES_W] ? BYTES_MAX : part_bytes[BYTES_W-1:0];
						state_q <= ST_RMUL;
					end
				end
				ST_RMUL: begin
					if (bytes_q == '0) begin
						res_q   <= '0;
						state_q <= ST_OUT;
					end else if (t_q == '0) begin
						res_q   <= RATE_MAX;
						state_q <= ST_OUT;
					end else begin
						prod_q  <= {14'b0, ({10'b0, bytes_q} * {32'b0, MS_PER_S})};
						state_q <= ST_RSTART;
					end
				end
				ST_RSTART: begin
					if (rate_sat) begin
						res_q   <= RATE_MAX;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					if (div_rsp.done) begin
						res_q   <= div_rsp.quot[COUNT_W-1:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign rate_bytes_per_s = out_rate_q;

	// checks
	`WTE_ASSERT_NXT(a_clear_zeroes, clk, arst_n, in_acc && cmd == CMD_CLEAR, bucket_time_q[0] == '0 && bucket_bytes_q[0] == '0, "clear left history")
	`WTE_ASSERT_IMP(a_cross_fills, clk, arst_n, state_q == ST_RMUL && cross_q, t_q == win_q, "straddling bucket did not fill window")
	`WTE_ASSERT_IMP(a_div_owner, clk, arst_n, div_rsp.busy, state_q == ST_PDIV || state_q == ST_RDIV, "divider busy outside a divide state")

endmodule
